>>> rtl/tccw_pkg.sv
// Shared types, sizes and character codes for the text console cursor writer.
package tccw_pkg;

  // Screen geometry and tab stops.
  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int TAB_WIDTH      = 8;

  // Widths of the cursor, the cell index and the byte address.
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int IDX_W  = 12;
  localparam int ADDR_W = 32;

  // Base address after reset.
  localparam logic [ADDR_W-1:0] BASE_RESET = 32'h000B_8000;

  // Control characters.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // One input word: a character and its attribute.
  typedef struct packed {
    logic [7:0] char_code;
    logic [7:0] attribute;
  } char_word_t;

  // One output word: a video-memory write command.
  typedef struct packed {
    logic              write_valid;
    logic [ADDR_W-1:0] cell_byte_address;
    logic [7:0]        cell_char;
    logic [7:0]        cell_attribute;
    logic              line_advanced;
  } cmd_word_t;

endpackage

>>> rtl/tccw_cursor.sv
// Cursor registers and the per-character update and address logic.
module tccw_cursor
  import tccw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  char_word_t        item,
  input  logic [ADDR_W-1:0] base,
  output cmd_word_t         result
);

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic [ROW_W-1:0] row_inc;
  logic [COL_W:0]   tab_col;
  logic [COL_W-1:0] wr_col;
  logic [ROW_W-1:0] wr_row;
  logic [IDX_W-1:0] cell_idx;
  logic             wr;
  logic             adv;
  logic [7:0]       wr_char;

  // Row after a line advance, wrapping at the bottom of the screen.
  assign row_inc = (row == ROW_W'(SCREEN_ROWS - 1)) ? '0 : row + 1'b1;

  // Next tab stop; the remainder is a mask since the tab width is a power of two.
  assign tab_col = {1'b0, col} + (COL_W+1)'(TAB_WIDTH)
                 - {1'b0, col % COL_W'(TAB_WIDTH)};

  // Decode the character and work out the new cursor and the cell to write.
  always_comb begin
    col_next = col;
    row_next = row;
    wr_col   = col;
    wr_row   = row;
    wr       = 1'b0;
    adv      = 1'b0;
    wr_char  = item.char_code;
    case (item.char_code)
      CH_NUL: begin
      end
      CH_LF: begin
        col_next = '0;
        row_next = row_inc;
        adv      = 1'b1;
      end
      CH_CR: begin
        col_next = '0;
      end
      CH_BS: begin
        if (col != '0 || row != '0) begin
          if (col == '0) begin
            col_next = COL_W'(SCREEN_COLUMNS - 1);
            row_next = row - 1'b1;
          end else begin
            col_next = col - 1'b1;
          end
          wr_col  = col_next;
          wr_row  = row_next;
          wr      = 1'b1;
          wr_char = CH_SPACE;
        end
      end
      CH_TAB: begin
        if (tab_col >= (COL_W+1)'(SCREEN_COLUMNS)) begin
          col_next = '0;
          row_next = row_inc;
          adv      = 1'b1;
        end else begin
          col_next = tab_col[COL_W-1:0];
        end
      end
      default: begin
        wr = 1'b1;
        if (col == COL_W'(SCREEN_COLUMNS - 1)) begin
          col_next = '0;
          row_next = row_inc;
          adv      = 1'b1;
        end else begin
          col_next = col + 1'b1;
        end
      end
    endcase
  end

  // Cell index and byte address of the written cell.
  assign cell_idx = IDX_W'(wr_row) * IDX_W'(SCREEN_COLUMNS) + IDX_W'(wr_col);

  // Write fields of a word with no write are zero; line_advanced still shows adv.
  always_comb begin
    result.write_valid       = wr;
    result.cell_byte_address = wr ? base + ADDR_W'({cell_idx, 1'b0}) : '0;
    result.cell_char         = wr ? wr_char : '0;
    result.cell_attribute    = wr ? item.attribute : '0;
    result.line_advanced     = adv;
  end

  // Cursor registers move once per character taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (step) begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

>>> rtl/text_console_cursor_writer_top.sv
// Top level: input register, cursor unit, output register and base register.
//
// Channels. Character words (char_code, attribute) enter on char_valid /
// char_stall / char_word and are taken at an edge with valid high and stall
// low. Each word yields exactly one command word on cmd_valid / cmd_stall /
// cmd_word: a video-memory write (write_valid, cell_byte_address, cell_char,
// cell_attribute) and the line_advanced flag. The base address of cell 0 is
// written through cfg_valid / cfg_ready / cfg_data, by the user only while no
// word is in flight (not enforced by the block); cfg_ready is always high.
//
// Pipeline. A taken word is registered in the input register. From there the
// cursor unit computes the command, and the command is registered in the output
// register at the same edge that updates column and row. One word is taken every
// cycle while the receiver does not stall.
//
// Reset clears both stages, puts the cursor at column 0, row 0 and loads the
// base address 0xB8000. When the receiver stalls, the command holds and the
// input register keeps one more word; char_stall rises once both are full.
module text_console_cursor_writer_top
  import tccw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              char_valid,
  output logic              char_stall,
  input  char_word_t        char_word,
  output logic              cmd_valid,
  input  logic              cmd_stall,
  output cmd_word_t         cmd_word,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ADDR_W-1:0] cfg_data
);

  logic              s1_valid;
  char_word_t        s1_word;
  logic              out_adv;
  logic              s1_adv;
  logic [ADDR_W-1:0] base;
  cmd_word_t         result;

  // Stage enables: the output moves when empty or taken, the input follows.
  assign out_adv    = !cmd_valid || !cmd_stall;
  assign s1_adv     = !s1_valid || out_adv;
  assign char_stall = !s1_adv;
  assign cfg_ready  = 1'b1;

  // Base address register.
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      base <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && char_valid) begin
      s1_word <= char_word;
    end
  end

  // Cursor update and command formation.
  tccw_cursor u_cursor (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_valid && out_adv),
    .item   (s1_word),
    .base   (base),
    .result (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (out_adv) begin
      cmd_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid) begin
      cmd_word <= result;
    end
  end

endmodule
